>>> design/rhks_pkg.sv
package rhks_pkg;

   // Sizes of the schedule and of the transaction fields
   localparam int NUM_SEGMENTS = 5;
   localparam int TEMP_W       = 13;
   localparam int ELAPSED_W    = 16;
   localparam int WORD_W       = 44;
   localparam int RATE_W       = 18;
   localparam int TARGET_W     = 14;
   localparam int MINUTES_W    = 12;
   localparam int HOLD_W       = 28;
   localparam int SEG_W        = 3;
   localparam int COUNT_W      = 3;
   localparam int CSR_INDEX_W  = 3;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_WORD_4 = 3'd5;

   // Input commands
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Run phase codes, as reported in phase_now
   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_RAMP = 2'd1,
      PHASE_HOLD = 2'd2
   } phase_type;

   typedef struct packed {
      logic                 command;
      logic [TEMP_W-1:0]    temperature_q2;
      logic [ELAPSED_W-1:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic             relay_on;
      logic [1:0]       phase_now;
      logic [SEG_W-1:0] segment_now;
      logic             run_done;
   } rsp_type;

endpackage

>>> design/ramp_hold_kiln_sequencer.sv
// Ramp and hold heater sequencer, one result transaction per input transaction.
// The ramp rate test multiplies rate by elapsed time one bit per cycle,
// and segment skipping walks one segment per cycle.
// One transaction at a time; the next is taken once the result is registered.
// Reset (synchronous): idle, segment 0, relay open, count 5, segment words zero.
module ramp_hold_kiln_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [rhks_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rhks_pkg::WORD_W-1:0]         csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rhks_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rhks_pkg::rsp_type                   rsp_data
);
   import rhks_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RAMP,
      ST_WALK,
      ST_OUT
   } state_type;

   localparam int ACC_W = RATE_W + ELAPSED_W;
   localparam int LHS_W = ACC_W + 3;
   localparam logic signed [LHS_W-1:0] MS_PER_HOUR  = LHS_W'(3600000);
   localparam logic [HOLD_W-1:0]       MS_PER_MINUTE = HOLD_W'(60000);
   localparam logic [3:0]              MUL_LAST = 4'(ELAPSED_W - 1);

   // Configuration storage
   logic [COUNT_W-1:0]  count_ff;
   logic [WORD_W-1:0]   seg_word_ff [NUM_SEGMENTS];

   // Sequencer state
   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic [TEMP_W-1:0]   prev_ff, prev_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic                relay_ff, relay_in;
   logic                done_ff, done_in;

   // Per-transaction working registers
   logic [TEMP_W-1:0]       t_ff, t_in;
   logic signed [TEMP_W:0]  diff_ff, diff_in;
   logic [ELAPSED_W-1:0]    el_sr_ff, el_sr_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [LHS_W-1:0] lhs_ff, lhs_in;
   logic [3:0]              mul_cnt_ff, mul_cnt_in;
   logic [SEG_W-1:0]        walk_ff, walk_in;
   logic                    with_ramp_ff, with_ramp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Fields of the selected segment word
   logic [SEG_W-1:0]          rd_idx;
   logic [WORD_W-1:0]         word_sel;
   logic signed [RATE_W-1:0]  rate_sel;
   logic [TARGET_W+1:0]       tq_sel;
   logic [MINUTES_W-1:0]      min_sel;
   logic [HOLD_W-1:0]         hold_ms_sel;
   logic [TEMP_W-1:0]         t_cur;
   logic [TARGET_W+1:0]       t_cmp;
   logic                      pending_sel;
   logic [COUNT_W-1:0]        n_used;
   logic [HOLD_W-1:0]         el_ext;
   logic [HOLD_W-1:0]         hold_dec;
   logic signed [LHS_W-1:0]   rhs;
   logic                      req_fire;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Select one segment word: the walk pointer while skipping, else the active segment
   assign rd_idx   = (state_ff == ST_WALK) ? walk_ff : seg_ff;
   assign word_sel = (rd_idx < SEG_W'(NUM_SEGMENTS)) ? seg_word_ff[rd_idx] : '0;
   assign rate_sel = $signed(word_sel[43:26]);
   assign tq_sel   = {word_sel[25:12], 2'b00};
   assign min_sel  = word_sel[11:0];
   assign hold_ms_sel = {{(HOLD_W-MINUTES_W){1'b0}}, min_sel} * MS_PER_MINUTE;

   // Ramp is still pending when the target lies ahead in the rate's direction
   assign t_cur = (state_ff == ST_IDLE) ? req_data.temperature_q2 : t_ff;
   assign t_cmp = {{(TARGET_W+2-TEMP_W){1'b0}}, t_cur};
   assign pending_sel = (!rate_sel[RATE_W-1] && (rate_sel != '0) && (t_cmp < tq_sel))
                     || (rate_sel[RATE_W-1] && (t_cmp > tq_sel));

   // Clamp the segment count into 1..NUM_SEGMENTS
   always_comb begin
      if (count_ff == '0) begin
         n_used = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(NUM_SEGMENTS)) begin
         n_used = COUNT_W'(NUM_SEGMENTS);
      end else begin
         n_used = count_ff;
      end
   end

   // Saturating hold countdown
   assign el_ext   = {{(HOLD_W-ELAPSED_W){1'b0}}, req_data.elapsed_ms};
   assign hold_dec = (hold_ff > el_ext) ? (hold_ff - el_ext) : '0;

   // Right side of the rate test: rate * 4 * elapsed
   assign rhs = {{(LHS_W-ACC_W-2){acc_ff[ACC_W-1]}}, acc_ff, 2'b00};

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(NUM_SEGMENTS);
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            seg_word_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index == CSR_SEGMENT_COUNT) begin
            count_ff <= csr_data[COUNT_W-1:0];
         end else if (csr_index >= CSR_SEGMENT_WORD_0 && csr_index <= CSR_SEGMENT_WORD_4) begin
            seg_word_ff[csr_index - CSR_SEGMENT_WORD_0] <= csr_data;
         end
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      seg_in       = seg_ff;
      prev_in      = prev_ff;
      hold_in      = hold_ff;
      relay_in     = relay_ff;
      done_in      = done_ff;
      t_in         = t_ff;
      diff_in      = diff_ff;
      el_sr_in     = el_sr_ff;
      acc_in       = acc_ff;
      lhs_in       = lhs_ff;
      mul_cnt_in   = mul_cnt_ff;
      walk_in      = walk_ff;
      with_ramp_in = with_ramp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the result once it is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               t_in     = req_data.temperature_q2;
               diff_in  = $signed({1'b0, req_data.temperature_q2}) - $signed({1'b0, prev_ff});
               prev_in  = req_data.temperature_q2;
               el_sr_in = req_data.elapsed_ms;
               done_in  = 1'b0;
               if (req_data.command == CMD_START) begin
                  relay_in     = 1'b0;
                  walk_in      = '0;
                  with_ramp_in = 1'b1;
                  state_in     = ST_WALK;
               end else begin
                  case (phase_ff)
                     PHASE_RAMP: begin
                        acc_in     = '0;
                        mul_cnt_in = '0;
                        state_in   = ST_MUL;
                     end
                     PHASE_HOLD: begin
                        relay_in = (t_cmp <= tq_sel);
                        hold_in  = hold_dec;
                        if (hold_dec == '0) begin
                           walk_in      = seg_ff + SEG_W'(1);
                           with_ramp_in = 1'b1;
                           state_in     = ST_WALK;
                        end else begin
                           state_in = ST_OUT;
                        end
                     end
                     default: begin
                        phase_in = PHASE_IDLE;
                        relay_in = 1'b0;
                        state_in = ST_OUT;
                     end
                  endcase
               end
            end
         end

         // Shift-add rate * elapsed, elapsed bits MSB first
         ST_MUL: begin
            acc_in = (acc_ff <<< 1)
                   + (el_sr_ff[ELAPSED_W-1] ? ACC_W'(rate_sel) : ACC_W'(0));
            el_sr_in = el_sr_ff << 1;
            lhs_in   = LHS_W'(diff_ff) * MS_PER_HOUR;
            mul_cnt_in = mul_cnt_ff + 4'd1;
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = ST_RAMP;
            end
         end

         // Decide the relay and whether the ramp has reached its target
         ST_RAMP: begin
            relay_in = (lhs_ff <= rhs);
            if (!pending_sel) begin
               walk_in      = seg_ff;
               with_ramp_in = 1'b0;
               state_in     = ST_WALK;
            end else begin
               state_in = ST_OUT;
            end
         end

         // Advance one segment per cycle until one has work left or the schedule ends
         ST_WALK: begin
            if (walk_ff >= n_used) begin
               seg_in   = n_used - COUNT_W'(1);
               phase_in = PHASE_IDLE;
               hold_in  = '0;
               relay_in = 1'b0;
               done_in  = 1'b1;
               state_in = ST_OUT;
            end else if (with_ramp_ff && pending_sel) begin
               seg_in   = walk_ff;
               phase_in = PHASE_RAMP;
               state_in = ST_OUT;
            end else if (hold_ms_sel != '0) begin
               seg_in   = walk_ff;
               phase_in = PHASE_HOLD;
               hold_in  = hold_ms_sel;
               state_in = ST_OUT;
            end else begin
               walk_in      = walk_ff + SEG_W'(1);
               with_ramp_in = 1'b1;
            end
         end

         // Hand the result to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.relay_on    = relay_ff;
               rsp_data_in.phase_now   = phase_ff;
               rsp_data_in.segment_now = seg_ff;
               rsp_data_in.run_done    = done_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_IDLE;
         seg_ff       <= '0;
         prev_ff      <= '0;
         hold_ff      <= '0;
         relay_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_cnt_ff   <= '0;
         walk_ff      <= '0;
         with_ramp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         seg_ff       <= seg_in;
         prev_ff      <= prev_in;
         hold_ff      <= hold_in;
         relay_ff     <= relay_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_cnt_ff   <= mul_cnt_in;
         walk_ff      <= walk_in;
         with_ramp_ff <= with_ramp_in;
      end
      t_ff        <= t_in;
      diff_ff     <= diff_in;
      el_sr_ff    <= el_sr_in;
      acc_ff      <= acc_in;
      lhs_ff      <= lhs_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> dv/ramp_hold_kiln_sequencer_test.sv
`timescale 1ns / 1ps

module ramp_hold_kiln_sequencer_test;
   import rhks_pkg::*;

   localparam int     SETTLE_CYCLES = 30;
   localparam int     RANDOM_ITEMS  = 1950;
   localparam longint MS_PER_HOUR   = 3600000;
   localparam int     MS_PER_MINUTE = 60000;
   localparam int     TEMP_MAX      = (1 << TEMP_W) - 1;
   localparam int     ELAPSED_MAX   = (1 << ELAPSED_W) - 1;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_data;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;

   ramp_hold_kiln_sequencer dut (.*);

   // Shadow copy of the schedule registers and the run state
   logic [COUNT_W-1:0] sched_count;
   logic [WORD_W-1:0]  sched_words [NUM_SEGMENTS];
   phase_type          run_phase;
   int unsigned        run_segment;
   logic [TEMP_W-1:0]  last_temp;
   logic [HOLD_W-1:0]  hold_left_ms;
   logic               relay_closed;
   logic               run_finished;

   rsp_type pending_responses[$];
   int      mismatch_count = 0;
   int      burst_left;

   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] index;
      logic [WORD_W-1:0]      value;
      req_type                item;
      bit                     typed;
      rsp_type                want;
   } plan_row;

   plan_row directed_plan[$];

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop for a hung run
   initial begin
      #8_000_000;
      $display("ramp_hold_kiln_sequencer_test NOT OK");
      $finish;
   end

   function automatic int unsigned segments_in_use();
      int unsigned n;
      n = sched_count;
      if (n < 1) n = 1;
      if (n > NUM_SEGMENTS) n = NUM_SEGMENTS;
      return n;
   endfunction

   function automatic longint seg_rate(int unsigned s);
      return longint'($signed(sched_words[s][WORD_W-1 -: RATE_W]));
   endfunction

   function automatic int unsigned seg_target_q2(int unsigned s);
      return int'(sched_words[s][MINUTES_W +: TARGET_W]) * 4;
   endfunction

   function automatic logic [HOLD_W-1:0] seg_hold_ms(int unsigned s);
      return HOLD_W'(int'(sched_words[s][MINUTES_W-1:0]) * MS_PER_MINUTE);
   endfunction

   // Ramp still has ground to cover in the direction of the rate
   function automatic bit ramp_open(int unsigned s, int unsigned t);
      longint      rate;
      int unsigned tq;
      rate = seg_rate(s);
      tq   = seg_target_q2(s);
      return (rate > 0 && t < tq) || (rate < 0 && t > tq);
   endfunction

   // Walk forward from start_seg, skipping segments that have nothing to do
   function automatic void enter_segment(int unsigned start_seg, int unsigned t, bit with_ramp);
      int unsigned s;
      int unsigned n;
      n = segments_in_use();
      s = start_seg;
      while (s < n) begin
         if (with_ramp && ramp_open(s, t)) begin
            run_segment = s;
            run_phase   = PHASE_RAMP;
            return;
         end
         with_ramp = 1'b1;
         if (seg_hold_ms(s) != '0) begin
            run_segment  = s;
            run_phase    = PHASE_HOLD;
            hold_left_ms = seg_hold_ms(s);
            return;
         end
         s++;
      end
      run_segment  = n - 1;
      run_phase    = PHASE_IDLE;
      hold_left_ms = '0;
      relay_closed = 1'b0;
      run_finished = 1'b1;
   endfunction

   // Advance the shadow state by one transaction and return its response
   function automatic rsp_type predict_kiln_response(req_type item);
      int unsigned t;
      int unsigned s;
      longint      rise;
      longint      allowed;
      rsp_type     r;
      t = item.temperature_q2;
      s = run_segment;
      run_finished = 1'b0;
      if (item.command == CMD_START) begin
         relay_closed = 1'b0;
         enter_segment(0, t, 1'b1);
      end else if (run_phase == PHASE_RAMP) begin
         rise    = (longint'(t) - longint'(last_temp)) * MS_PER_HOUR;
         allowed = seg_rate(s) * 4 * longint'(item.elapsed_ms);
         relay_closed = (rise <= allowed);
         if (!ramp_open(s, t)) enter_segment(s, t, 1'b0);
      end else if (run_phase == PHASE_HOLD) begin
         relay_closed = (t <= seg_target_q2(s));
         hold_left_ms = (hold_left_ms > item.elapsed_ms) ? hold_left_ms - item.elapsed_ms : '0;
         if (hold_left_ms == '0) enter_segment(s + 1, t, 1'b1);
      end else begin
         relay_closed = 1'b0;
      end
      last_temp     = item.temperature_q2;
      r.relay_on    = relay_closed;
      r.phase_now   = run_phase;
      r.segment_now = SEG_W'(run_segment);
      r.run_done    = run_finished;
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp_data, 0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.relay_on !== want.relay_on)
               report_mismatch("relay_on", rsp_data.relay_on, want.relay_on);
            if (rsp_data.phase_now !== want.phase_now)
               report_mismatch("phase_now", rsp_data.phase_now, want.phase_now);
            if (rsp_data.segment_now !== want.segment_now)
               report_mismatch("segment_now", rsp_data.segment_now, want.segment_now);
            if (rsp_data.run_done !== want.run_done)
               report_mismatch("run_done", rsp_data.run_done, want.run_done);
         end
      end
   end

   // Stall the response channel in changing patterns
   initial begin
      int mode;
      int span;
      rsp_stall <= 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 300);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 15) != 0);
            endcase
         end
      end
   end

   // Offer one transaction, hold it until taken, then maybe open a gap
   task automatic send_request(req_type item, bit typed, rsp_type want);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_kiln_response(item);
      pending_responses.push_back(typed ? want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end
   endtask

   // Drop valid, drain all responses and let the block settle
   task automatic wait_for_quiet();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [WORD_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (index == CSR_SEGMENT_COUNT)
         sched_count = value[COUNT_W-1:0];
      else if (index >= CSR_SEGMENT_WORD_0 && index <= CSR_SEGMENT_WORD_4)
         sched_words[index - CSR_SEGMENT_WORD_0] = value;
   endtask

   function automatic logic [WORD_W-1:0] segment_word(int rate, int target_f, int minutes);
      return {RATE_W'(rate), TARGET_W'(target_f), MINUTES_W'(minutes)};
   endfunction

   function automatic void plan_write(logic [CSR_INDEX_W-1:0] index, logic [WORD_W-1:0] value);
      plan_row row;
      row          = '{default: '0};
      row.is_write = 1'b1;
      row.index    = index;
      row.value    = value;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_item(logic cmd, int t, int el);
      plan_row row;
      row      = '{default: '0};
      row.item = '{command: cmd, temperature_q2: TEMP_W'(t), elapsed_ms: ELAPSED_W'(el)};
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_known(logic cmd, int t, int el, logic relay, phase_type ph,
                                      int seg, logic done);
      plan_item(cmd, t, el);
      directed_plan[$].typed = 1'b1;
      directed_plan[$].want  = '{relay_on: relay, phase_now: ph, segment_now: SEG_W'(seg),
                                 run_done: done};
   endfunction

   function automatic logic [WORD_W-1:0] random_segment();
      int rate;
      int target_f;
      int minutes;
      int pick;
      if ($urandom_range(0, 29) == 0) return ($urandom_range(0, 1) == 0) ? '0 : '1;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         rate = 0;
      end else if (pick == 2) begin
         rate = $urandom_range(0, (1 << RATE_W) - 1);
      end else begin
         rate = $urandom_range(1, 900);
         if ($urandom_range(0, 3) == 0) rate = -rate;
      end
      target_f = ($urandom_range(0, 19) == 0) ? $urandom_range(0, (1 << TARGET_W) - 1)
                                               : $urandom_range(0, 2047);
      pick = $urandom_range(0, 19);
      if (pick < 8)       minutes = 0;
      else if (pick < 19) minutes = $urandom_range(1, 2);
      else                minutes = $urandom_range(0, (1 << MINUTES_W) - 1);
      return segment_word(rate, target_f, minutes);
   endfunction

   function automatic int random_elapsed();
      int pick;
      pick = $urandom_range(0, 24);
      if (pick == 0) return 0;
      if (pick == 1) return ELAPSED_MAX;
      return $urandom_range(1, ELAPSED_MAX);
   endfunction

   // Sample that mostly moves the temperature toward the target in a ramp, stays near it in a hold, else random
   function automatic req_type steered_sample();
      int      t;
      int      tq;
      int      stride;
      req_type item;
      t = last_temp;
      if (run_phase == PHASE_RAMP) begin
         tq     = seg_target_q2(run_segment);
         stride = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 400);
         if ($urandom_range(0, 7) == 0) stride = -stride / 4;
         t = (tq > t) ? t + stride : t - stride;
      end else if (run_phase == PHASE_HOLD) begin
         stride = $urandom_range(0, 60);
         t = int'(seg_target_q2(run_segment)) + stride - 30;
      end else begin
         t = $urandom_range(0, TEMP_MAX);
      end
      if (t < 0) t = 0;
      if (t > TEMP_MAX) t = TEMP_MAX;
      item.command        = CMD_SAMPLE;
      item.temperature_q2 = TEMP_W'(t);
      item.elapsed_ms     = ELAPSED_W'(random_elapsed());
      return item;
   endfunction

   // Main stimulus: reset, directed table, then random firing runs
   initial begin
      logic [WORD_W-1:0] directed_words [NUM_SEGMENTS];
      bit                busy;
      int                random_sent;
      int                run_length;
      req_type           item;

      reset     <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      req_valid <= 1'b0;
      req_data  <= '0;
      burst_left = 0;

      // Shadow state after reset
      sched_count  = COUNT_W'(NUM_SEGMENTS);
      foreach (sched_words[i]) sched_words[i] = '0;
      run_phase    = PHASE_IDLE;
      run_segment  = 0;
      last_temp    = '0;
      hold_left_ms = '0;
      relay_closed = 1'b0;
      run_finished = 1'b0;

      // Idle samples, then starts on an empty schedule with the count at its extremes
      plan_known(CMD_SAMPLE, 0, 1, 1'b0, PHASE_IDLE, 0, 1'b0);
      plan_known(CMD_SAMPLE, TEMP_MAX, ELAPSED_MAX, 1'b0, PHASE_IDLE, 0, 1'b0);
      plan_known(CMD_START, 100, 1, 1'b0, PHASE_IDLE, NUM_SEGMENTS - 1, 1'b1);
      plan_write(CSR_SEGMENT_COUNT, '0);
      plan_known(CMD_START, 0, 0, 1'b0, PHASE_IDLE, 0, 1'b1);
      plan_write(CSR_SEGMENT_COUNT, '1);
      plan_known(CMD_START, TEMP_MAX, 0, 1'b0, PHASE_IDLE, NUM_SEGMENTS - 1, 1'b1);

      // Heat, skip a dead segment, cool, then a near-endless hold
      directed_words[0] = segment_word(100, 500, 1);
      directed_words[1] = segment_word(0, 300, 0);
      directed_words[2] = segment_word(-200, 200, 2);
      directed_words[3] = '1;
      directed_words[4] = segment_word((1 << (RATE_W - 1)) - 1, 0, 0);
      for (int i = 0; i < NUM_SEGMENTS; i++)
         plan_write(CSR_SEGMENT_WORD_0 + CSR_INDEX_W'(i), directed_words[i]);
      plan_write(CSR_SEGMENT_COUNT, COUNT_W'(NUM_SEGMENTS));
      plan_item(CMD_START, 1000, 1);
      plan_item(CMD_SAMPLE, 1004, 1000);
      plan_item(CMD_SAMPLE, 1010, ELAPSED_MAX);
      plan_item(CMD_SAMPLE, 2000, 0);
      plan_item(CMD_SAMPLE, 2001, ELAPSED_MAX);
      plan_item(CMD_SAMPLE, 1500, 30000);
      plan_item(CMD_SAMPLE, 1499, 60000);
      plan_item(CMD_SAMPLE, 800, 1);
      plan_item(CMD_SAMPLE, 801, ELAPSED_MAX);
      plan_item(CMD_SAMPLE, 700, ELAPSED_MAX);
      plan_item(CMD_SAMPLE, TEMP_MAX, ELAPSED_MAX);
      plan_item(CMD_SAMPLE, TEMP_MAX, 0);

      // Restart mid-run, then lower the count under a running hold
      plan_item(CMD_START, 3000, ELAPSED_MAX);
      plan_write(CSR_SEGMENT_COUNT, 1);
      plan_item(CMD_SAMPLE, 1999, ELAPSED_MAX);
      plan_item(CMD_SAMPLE, 50, 100);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      busy = 1'b0;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) begin
            if (busy) wait_for_quiet();
            busy = 1'b0;
            write_register(directed_plan[i].index, directed_plan[i].value);
         end else begin
            send_request(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
            busy = 1'b1;
         end
      end

      // Random firing runs with occasional noise
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            wait_for_quiet();
            write_register(CSR_SEGMENT_COUNT, ($urandom_range(0, 9) < 7) ?
                           COUNT_W'($urandom_range(3, NUM_SEGMENTS)) :
                           COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1)));
            for (int i = 0; i < NUM_SEGMENTS; i++)
               if ($urandom_range(0, 3) != 0)
                  write_register(CSR_SEGMENT_WORD_0 + CSR_INDEX_W'(i), random_segment());
         end else if ($urandom_range(0, 2) == 0) begin
            wait_for_quiet();
         end

         if ($urandom_range(0, 19) < 17 || run_phase == PHASE_IDLE) begin
            item.command        = CMD_START;
            item.temperature_q2 = TEMP_W'($urandom_range(0, 1200));
            item.elapsed_ms     = ELAPSED_W'(random_elapsed());
            send_request(item, 1'b0, '0);
            random_sent++;
         end

         run_length = $urandom_range(10, 70);
         repeat (run_length) begin
            if ($urandom_range(0, 15) == 0)
               item = req_type'($urandom_range(0, (1 << $bits(req_type)) - 1));
            else
               item = steered_sample();
            send_request(item, 1'b0, '0);
            random_sent++;
         end
      end

      wait_for_quiet();
      if (mismatch_count == 0)
         $display("ramp_hold_kiln_sequencer_test OK");
      else
         $display("ramp_hold_kiln_sequencer_test NOT OK");
      $finish;
   end

endmodule
